>>> hw/rtl/idhps_pkg.sv
// ----------------------------------------------------------------------------
// idhps_pkg
// Shared types and constants for the interval-day hourly pump scheduler.
// ----------------------------------------------------------------------------
package idhps_pkg;

  localparam int unsigned NumSlots = 5;

  localparam logic [4:0] HourNone   = 5'd31;
  localparam logic [4:0] Midnight   = 5'd24;
  localparam logic [4:0] LastHour   = 5'd23;
  localparam logic [5:0] ArmSeconds = 6'd9;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [2:0] {
    REG_INTERVAL_DAYS = 3'd0,
    REG_START_HOUR_A  = 3'd1,
    REG_START_HOUR_B  = 3'd2,
    REG_START_HOUR_C  = 3'd3,
    REG_START_HOUR_D  = 3'd4,
    REG_START_HOUR_E  = 3'd5,
    REG_RUN_TICKS     = 3'd6,
    REG_POWER_ON_HOUR = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]                 interval_days;
    logic [NumSlots-1:0][4:0]   start_hour;     // [0] is slot a
    logic [15:0]                run_ticks;
    logic [4:0]                 power_on_hour;
  } cfg_t;

  typedef struct packed {
    logic       valve_b_open;
    logic       valve_a_open;
    logic       tank_level_ok;
    logic [5:0] clock_second;
    logic [5:0] clock_minute;
    logic [4:0] clock_hour;
  } tick_t;

  typedef struct packed {
    logic       open_valve_b;
    logic       close_valve_a;
    logic [2:0] armed_slot;
    logic       pump_running;
  } result_t;

endpackage

>>> hw/rtl/idhps_core.sv
// ----------------------------------------------------------------------------
// idhps_core
// Scheduler state and per-tick update: day phase, hourly arming, pump run.
// ----------------------------------------------------------------------------
module idhps_core import idhps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,     // advance state with tick_i this cycle
  input  cfg_t    cfg_i,
  input  tick_t   tick_i,
  output result_t result_o    // result of tick_i, valid with step_i
);

  logic        pump_on_q, pump_on_d;
  logic [2:0]  slot_q, slot_d;
  logic [15:0] run_cnt_q, run_cnt_d;
  logic [4:0]  checked_hour_q, checked_hour_d;
  logic [4:0]  prev_hour_q, prev_hour_d;
  logic        rollover_seen_q, rollover_seen_d;
  logic        first_day_q, first_day_d;
  logic [7:0]  day_phase_q, day_phase_d;

  logic [4:0]  hour24;
  logic [4:0]  limit;
  logic [8:0]  phase_inc;
  logic [16:0] cnt_inc;
  logic [2:0]  arm_slot;
  logic        arm_hit;
  logic        close_a, open_b;

  assign hour24    = (tick_i.clock_hour == '0) ? Midnight : tick_i.clock_hour;
  assign phase_inc = {1'b0, day_phase_q} + 9'd1;
  assign cnt_inc   = {1'b0, run_cnt_q} + 17'd1;

  always_comb begin
    pump_on_d       = pump_on_q;
    slot_d          = slot_q;
    run_cnt_d       = run_cnt_q;
    checked_hour_d  = checked_hour_q;
    prev_hour_d     = prev_hour_q;
    rollover_seen_d = rollover_seen_q;
    first_day_d     = first_day_q;
    day_phase_d     = day_phase_q;
    close_a         = 1'b0;
    open_b          = 1'b0;
    limit           = '0;
    arm_slot        = '0;
    arm_hit         = 1'b0;

    // scheduling freezes entirely while the interval is zero
    if (cfg_i.interval_days != '0) begin
      if (tick_i.clock_hour == '0 && prev_hour_q == LastHour) begin
        if (!rollover_seen_q) begin
          day_phase_d     = (phase_inc >= {1'b0, cfg_i.interval_days}) ? '0 : phase_inc[7:0];
          first_day_d     = 1'b0;
          rollover_seen_d = 1'b1;
        end
      end else if (tick_i.clock_hour != '0) begin
        rollover_seen_d = 1'b0;
      end

      // first day: skip start hours up to the power-on hour
      if (first_day_d) begin
        limit = (cfg_i.power_on_hour == '0) ? Midnight : cfg_i.power_on_hour;
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (cfg_i.start_hour[i] != '0 && hour24 == cfg_i.start_hour[i] &&
            !(first_day_d && cfg_i.start_hour[i] <= limit)) begin
          arm_slot = 3'(i + 1);
          arm_hit  = 1'b1;
        end
      end

      if (tick_i.clock_minute == '0 && tick_i.clock_second < ArmSeconds) begin
        if (checked_hour_q != tick_i.clock_hour) begin
          checked_hour_d = tick_i.clock_hour;
          if (day_phase_d == '0 && !pump_on_q && tick_i.tank_level_ok && arm_hit) begin
            slot_d = arm_slot;
          end
        end
      end else if (tick_i.clock_minute != '0) begin
        checked_hour_d = HourNone;
      end

      prev_hour_d = tick_i.clock_hour;
    end

    // pump handling
    if (!tick_i.tank_level_ok) begin
      if (pump_on_q) begin
        run_cnt_d = '0;
        pump_on_d = 1'b0;
        slot_d    = '0;
      end
    end else if (slot_d != '0 && cfg_i.run_ticks != '0) begin
      if (!pump_on_q) begin
        run_cnt_d = '0;
        close_a   = tick_i.valve_a_open;
        open_b    = !tick_i.valve_b_open;
        pump_on_d = 1'b1;
      end else if (cnt_inc >= {1'b0, cfg_i.run_ticks}) begin
        run_cnt_d = '0;
        pump_on_d = 1'b0;
        slot_d    = '0;
      end else begin
        run_cnt_d = cnt_inc[15:0];
      end
    end else begin
      // no slot, or zero run length cancels an armed slot
      if (slot_d != '0) begin
        slot_d = '0;
      end
      if (pump_on_q) begin
        run_cnt_d = '0;
        pump_on_d = 1'b0;
      end
    end
  end

  assign result_o.pump_running  = pump_on_d;
  assign result_o.armed_slot    = slot_d;
  assign result_o.close_valve_a = close_a;
  assign result_o.open_valve_b  = open_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_on_q       <= 1'b0;
      slot_q          <= '0;
      run_cnt_q       <= '0;
      checked_hour_q  <= HourNone;
      prev_hour_q     <= HourNone;
      rollover_seen_q <= 1'b0;
      first_day_q     <= 1'b1;
      day_phase_q     <= '0;
    end else if (step_i) begin
      pump_on_q       <= pump_on_d;
      slot_q          <= slot_d;
      run_cnt_q       <= run_cnt_d;
      checked_hour_q  <= checked_hour_d;
      prev_hour_q     <= prev_hour_d;
      rollover_seen_q <= rollover_seen_d;
      first_day_q     <= first_day_d;
      day_phase_q     <= day_phase_d;
    end
  end

endmodule

>>> hw/rtl/interval_day_hourly_pump_scheduler.sv
// Pipeline: a tick is captured in the input register, then its result in the
// result register. Throughput: one tick per cycle unless the result stream
// stalls; the state update is a single pass between the two registers, and
// the output stage is released whenever it is taken.
// Reset: all scheduler state and both pipeline stages clear; registers reset
// to zero, marks to "none", first-day set.
// ----------------------------------------------------------------------------
// interval_day_hourly_pump_scheduler
// Interval-day hourly pump scheduler with stream in/out and a config port.
// ----------------------------------------------------------------------------
module interval_day_hourly_pump_scheduler import idhps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  // tick stream in
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // clock_hour[4:0], clock_minute[10:5], clock_second[16:11],
  // tank_level_ok[17], valve_a_open[18], valve_b_open[19], zero[23:20]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // result stream out
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // pump_running[0], armed_slot[3:1], close_valve_a[4], open_valve_b[5],
  // zero[7:6]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cfg_t    cfg_q;
  tick_t   tick_q;
  logic    in_vld_q;
  result_t res_q;
  logic    out_vld_q;
  result_t core_res;
  logic    out_free;
  logic    step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INTERVAL_DAYS: cfg_q.interval_days <= cfg_data_i[7:0];
        REG_START_HOUR_A:  cfg_q.start_hour[0] <= cfg_data_i[4:0];
        REG_START_HOUR_B:  cfg_q.start_hour[1] <= cfg_data_i[4:0];
        REG_START_HOUR_C:  cfg_q.start_hour[2] <= cfg_data_i[4:0];
        REG_START_HOUR_D:  cfg_q.start_hour[3] <= cfg_data_i[4:0];
        REG_START_HOUR_E:  cfg_q.start_hour[4] <= cfg_data_i[4:0];
        REG_RUN_TICKS:     cfg_q.run_ticks     <= cfg_data_i;
        REG_POWER_ON_HOUR: cfg_q.power_on_hour <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // two-stage pipe: input register feeds the core, core writes result register
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      tick_q <= tick_t'(s_axis_tdata_i[$bits(tick_t)-1:0]);
    end
    if (step) begin
      res_q <= core_res;
    end
  end

  idhps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .tick_i   (tick_q),
    .result_o (core_res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OutDataW - $bits(result_t))'(0), res_q};

endmodule

>>> tb/interval_day_hourly_pump_scheduler_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_day_hourly_pump_scheduler_chk
// Passive checker: tracks register writes, predicts the result of every
// accepted tick with a local copy of the scheduler state, and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module interval_day_hourly_pump_scheduler_chk import idhps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                tick_valid_i,
  input  logic                tick_ready_i,
  input  logic [InDataW-1:0]  tick_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  localparam int unsigned MaxPrinted = 100;

  // register copies
  logic [7:0]  interval_days;
  logic [4:0]  start_hour [1:NumSlots];
  logic [15:0] run_ticks;
  logic [4:0]  power_on_hour;

  // scheduler state
  logic        pump_on;
  logic [2:0]  slot_idx;
  logic [15:0] run_cnt;
  logic [4:0]  checked_hour;
  logic [4:0]  prev_hour;
  logic        rolled_over;
  logic        first_day;
  logic [7:0]  day_phase;

  result_t     pump_results_q [$];
  int unsigned err_cnt = 0;

  assign errors_o = err_cnt;

  task automatic note_mismatch(input string what, input int got, input int want);
    if (err_cnt < MaxPrinted)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic update_schedule(input tick_t t);
    logic [4:0] hour24;
    logic [8:0] next_phase;
    logic [4:0] skip_to;
    hour24 = (t.clock_hour == 5'd0) ? Midnight : t.clock_hour;
    if (interval_days != 8'd0) begin
      if (t.clock_hour == 5'd0 && prev_hour == LastHour) begin
        if (!rolled_over) begin
          next_phase = {1'b0, day_phase} + 9'd1;
          day_phase = (next_phase >= {1'b0, interval_days}) ? 8'd0 : next_phase[7:0];
          first_day = 1'b0;
          rolled_over = 1'b1;
        end
      end else if (t.clock_hour != 5'd0) begin
        rolled_over = 1'b0;
      end
      if (t.clock_minute == 6'd0 && t.clock_second < ArmSeconds) begin
        if (checked_hour != t.clock_hour) begin
          checked_hour = t.clock_hour;
          if (day_phase == 8'd0 && !pump_on && t.tank_level_ok) begin
            // on the first day, start hours up to power-on have already gone by
            skip_to = !first_day ? 5'd0 : (power_on_hour == 5'd0) ? Midnight : power_on_hour;
            for (int i = 1; i <= NumSlots; i++) begin
              if (start_hour[i] != 5'd0 && hour24 == start_hour[i] &&
                  !(first_day && start_hour[i] <= skip_to))
                slot_idx = 3'(i);
            end
          end
        end
      end else if (t.clock_minute != 6'd0) begin
        checked_hour = HourNone;
      end
      prev_hour = t.clock_hour;
    end
  endtask

  task automatic predict_tick(input tick_t t, output result_t r);
    logic [16:0] next_cnt;
    r = '0;
    update_schedule(t);
    if (!t.tank_level_ok) begin
      if (pump_on) begin
        run_cnt = '0;
        pump_on = 1'b0;
        slot_idx = '0;
      end
    end else if (slot_idx != 3'd0 && run_ticks != 16'd0) begin
      if (!pump_on) begin
        run_cnt = '0;
        r.close_valve_a = t.valve_a_open;
        r.open_valve_b = !t.valve_b_open;
        pump_on = 1'b1;
      end else begin
        // compare before truncation so a run always ends
        next_cnt = {1'b0, run_cnt} + 17'd1;
        if (next_cnt >= {1'b0, run_ticks}) begin
          run_cnt = '0;
          pump_on = 1'b0;
          slot_idx = '0;
        end else begin
          run_cnt = next_cnt[15:0];
        end
      end
    end else if (slot_idx == 3'd0) begin
      if (pump_on) begin
        run_cnt = '0;
        pump_on = 1'b0;
      end
    end else begin
      // armed with a zero run length: the run is dropped
      slot_idx = '0;
      if (pump_on) begin
        run_cnt = '0;
        pump_on = 1'b0;
      end
    end
    r.pump_running = pump_on;
    r.armed_slot = slot_idx;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      interval_days = '0;
      for (int i = 1; i <= NumSlots; i++) start_hour[i] = '0;
      run_ticks = '0;
      power_on_hour = '0;
      pump_on = 1'b0;
      slot_idx = '0;
      run_cnt = '0;
      checked_hour = HourNone;
      prev_hour = HourNone;
      rolled_over = 1'b0;
      first_day = 1'b1;
      day_phase = '0;
      pump_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_INTERVAL_DAYS: interval_days = cfg_data_i[7:0];
          REG_START_HOUR_A:  start_hour[1] = cfg_data_i[4:0];
          REG_START_HOUR_B:  start_hour[2] = cfg_data_i[4:0];
          REG_START_HOUR_C:  start_hour[3] = cfg_data_i[4:0];
          REG_START_HOUR_D:  start_hour[4] = cfg_data_i[4:0];
          REG_START_HOUR_E:  start_hour[5] = cfg_data_i[4:0];
          REG_RUN_TICKS:     run_ticks = cfg_data_i;
          REG_POWER_ON_HOUR: power_on_hour = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (tick_valid_i && tick_ready_i) begin
        predict_tick(tick_t'(tick_data_i[$bits(tick_t)-1:0]), want);
        pump_results_q.push_back(want);
      end
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i[$bits(result_t)-1:0]);
        if (pump_results_q.size() == 0) begin
          note_mismatch("unrequested result", int'(res_data_i), -1);
        end else begin
          want = pump_results_q.pop_front();
          if (got.pump_running !== want.pump_running)
            note_mismatch("pump_running", got.pump_running, want.pump_running);
          if (got.armed_slot !== want.armed_slot)
            note_mismatch("armed_slot", got.armed_slot, want.armed_slot);
          if (got.close_valve_a !== want.close_valve_a)
            note_mismatch("close_valve_a", got.close_valve_a, want.close_valve_a);
          if (got.open_valve_b !== want.open_valve_b)
            note_mismatch("open_valve_b", got.open_valve_b, want.open_valve_b);
          if (res_data_i[OutDataW-1:$bits(result_t)] !== '0)
            note_mismatch("tdata padding", int'(res_data_i[OutDataW-1:$bits(result_t)]), 0);
        end
      end
      pending_o <= pump_results_q.size();
    end
  end

endmodule

>>> tb/interval_day_hourly_pump_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_day_hourly_pump_scheduler_tb
// Drives register writes and clock-tick requests into the pump scheduler: a
// directed walk through arming, runs, rollovers and odd time values, then random
// phases of well-formed clock sequences with noise under several settings.
// Both stream sides idle in random bursts; the checker judges every result.
// ----------------------------------------------------------------------------
module interval_day_hourly_pump_scheduler_tb import idhps_pkg::*; ();

  localparam int unsigned RandomTicks = 2000;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned CalmTicks   = 200;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  int unsigned pending;
  int unsigned errors;
  int unsigned idle_pct = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rtc_hour = 7;
  int unsigned rtc_min = 0;
  int unsigned rtc_sec = 0;

  always #6 clk = ~clk;

  interval_day_hourly_pump_scheduler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  interval_day_hourly_pump_scheduler_chk u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .tick_valid_i (s_valid),
    .tick_ready_i (s_ready),
    .tick_data_i  (s_data),
    .res_valid_i  (m_valid),
    .res_ready_i  (m_ready),
    .res_data_i   (m_data),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  // result side back-pressure
  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[interval_day_hourly_pump_scheduler] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] days, input logic [4:0] hours [NumSlots],
                           input logic [15:0] ticks, input logic [4:0] boot_hour);
    write_reg(REG_INTERVAL_DAYS, 16'(days));
    for (int i = 0; i < NumSlots; i++)
      write_reg(cfg_reg_e'(REG_START_HOUR_A + i), 16'(hours[i]));
    write_reg(REG_RUN_TICKS, ticks);
    write_reg(REG_POWER_ON_HOUR, 16'(boot_hour));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {{(InDataW - $bits(tick_t)){1'b0}}, t};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic send_time(input int unsigned h, input int unsigned m, input int unsigned s,
                           input bit ok, input bit va, input bit vb);
    tick_t t;
    t.clock_hour = 5'(h);
    t.clock_minute = 6'(m);
    t.clock_second = 6'(s);
    t.tank_level_ok = ok;
    t.valve_a_open = va;
    t.valve_b_open = vb;
    send_tick(t);
  endtask

  // mostly a clock that moves forward hour by hour, with some noise
  task automatic next_random_tick(output tick_t t);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rtc_hour = (rtc_hour + 1) % 24;
      rtc_min = 0;
      rtc_sec = $urandom_range(0, 8);
    end else if (pick < 50) begin
      rtc_min = 0;
      rtc_sec = $urandom_range(0, 12);
    end else if (pick < 70) begin
      rtc_min = $urandom_range(1, 59);
      rtc_sec = $urandom_range(0, 59);
    end else if (pick < 80) begin
      // jump to the last hour so rollovers come often
      rtc_hour = LastHour;
      rtc_min = $urandom_range(0, 59);
      rtc_sec = $urandom_range(0, 59);
    end else if (pick < 88) begin
      rtc_hour = 0;
      rtc_min = 0;
      rtc_sec = $urandom_range(0, 8);
    end
    if (pick < 95) begin
      t.clock_hour = 5'(rtc_hour);
      t.clock_minute = 6'(rtc_min);
      t.clock_second = 6'(rtc_sec);
    end else begin
      t.clock_hour = 5'($urandom_range(0, 31));
      t.clock_minute = 6'($urandom_range(0, 63));
      t.clock_second = 6'($urandom_range(0, 63));
    end
    t.tank_level_ok = $urandom_range(0, 15) != 0;
    t.valve_a_open = $urandom_range(0, 1);
    t.valve_b_open = $urandom_range(0, 1);
  endtask

  initial begin
    logic [7:0]  days;
    logic [4:0]  hours [NumSlots];
    logic [15:0] ticks;
    logic [4:0]  boot_hour;
    tick_t       t;
    int unsigned sent;
    sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slots c and d share hour 6 so the later one must win
    hours = '{Midnight, 5'd5, 5'd6, 5'd6, 5'd31};
    configure(8'd1, hours, 16'd3, 5'd5);
    send_time(5, 0, 0, 1, 1, 0);     // first day, at power-on hour: skipped
    send_time(6, 0, 2, 1, 1, 0);     // arms, pump starts, both valve pulses
    send_time(6, 0, 3, 1, 0, 1);
    send_time(6, 0, 4, 1, 1, 0);
    send_time(6, 0, 5, 1, 1, 0);     // run ends
    send_time(6, 0, 6, 1, 1, 0);     // hour already checked
    send_time(23, 59, 59, 1, 0, 0);
    send_time(0, 0, 0, 1, 0, 1);     // rollover, midnight slot
    send_time(0, 0, 1, 0, 1, 1);     // level drop stops the run
    send_time(0, 0, 2, 1, 1, 1);
    send_time(0, 5, 0, 1, 0, 0);
    send_time(0, 0, 8, 1, 1, 0);     // same hour rearms after a minute change
    send_time(0, 0, 9, 1, 1, 0);
    send_time(0, 0, 10, 1, 1, 0);
    send_time(0, 0, 11, 1, 1, 0);
    send_time(31, 7, 0, 1, 0, 0);
    send_time(31, 0, 0, 1, 0, 0);    // hour 31 looks like the none mark
    send_time(25, 63, 63, 1, 1, 1);
    send_time(25, 0, 0, 1, 1, 1);
    send_time(23, 0, 0, 0, 0, 0);
    send_time(0, 0, 0, 1, 1, 0);
    send_time(7, 0, 0, 1, 0, 1);
    send_time(31, 63, 63, 1, 1, 1);

    for (int p = 0; p < NumPhases; p++) begin
      s_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
      days = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(1, 4));
      foreach (hours[i]) begin
        case ($urandom_range(0, 5))
          0: hours[i] = 5'd0;
          1: hours[i] = Midnight;
          2: hours[i] = 5'($urandom_range(25, 31));
          default: hours[i] = 5'($urandom_range(1, 23));
        endcase
      end
      ticks = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
      boot_hour = 5'($urandom_range(0, 31));
      case (p)
        0: days = 8'd0;
        1: begin
          days = 8'd255;
          ticks = 16'hffff;
          boot_hour = 5'd31;
        end
        2: begin
          days = 8'd1;
          ticks = 16'd0;
          boot_hour = 5'd0;
        end
        3: begin
          days = 8'd2;
          ticks = 16'd1;
          boot_hour = 5'd23;
        end
        default: ;
      endcase
      configure(days, hours, ticks, boot_hour);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      for (int k = 0; k < RandomTicks / NumPhases; k++) begin
        if (sent >= RandomTicks - CalmTicks)
          calm = 1'b1;
        next_random_tick(t);
        send_tick(t);
        sent++;
      end
    end

    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (errors == 0)
      $display("[interval_day_hourly_pump_scheduler] OK");
    else
      $display("[interval_day_hourly_pump_scheduler] ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/idhps_pkg.sv
hw/rtl/idhps_core.sv
hw/rtl/interval_day_hourly_pump_scheduler.sv
tb/interval_day_hourly_pump_scheduler_chk.sv
tb/interval_day_hourly_pump_scheduler_tb.sv
